/* rtl/ostt_pkg.sv */
// Shared types and constants for the one-shot tick timer.
`timescale 1ns / 1ps

package ostt_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_ONE_SHOT_MODE = 2'd0;
    localparam logic [1:0] REG_PERIOD_TICKS  = 2'd1;
    localparam logic [1:0] REG_IRQ_ENABLE    = 2'd2;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_ARM_WAKEUP = 2'd1;
    localparam logic [1:0] OP_ACK        = 2'd2;
    localparam logic [1:0] OP_READ_CLOCK = 2'd3;

    localparam logic [15:0] TICK_MUL     = 16'd60398;
    localparam logic [16:0] REM_STEP     = 17'd16384;
    localparam logic [31:0] MATCH_MAX    = 32'hFFFF_FFFF;
    localparam logic [31:0] PERIOD_RESET = 32'd3686;
    // smallest difference whose converted tick count exceeds 32 bits
    localparam logic [63:0] SAT_LIMIT    = 64'd1165084013;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] wakeup_us;
    } item_t;

    typedef struct packed {
        logic        irq_pending;
        logic [63:0] time_us;
        logic [31:0] match_ticks;
    } result_t;

    typedef struct packed {
        logic        one_shot_mode;
        logic [31:0] period_ticks;
        logic        irq_enable;
    } cfg_t;

endpackage

/* rtl/one_shot_tick_timer.sv */
// A transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle; the input register and the result
// register move together whenever the result is taken or the result slot is empty.
// Each transaction updates the timer state in the single step between the two.
// Reset: one-shot mode, period 3686, interrupt enabled, counter, flag and clock zero.
`timescale 1ns / 1ps

module one_shot_tick_timer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  ostt_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output ostt_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ostt_pkg::ADDR_W-1:0] paddr,
    input  logic [ostt_pkg::DATA_W-1:0] pwdata,
    output logic [ostt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    ostt_pkg::cfg_t    cfg;
    ostt_pkg::item_t   item_reg;
    logic              in_valid_reg;
    ostt_pkg::result_t result_reg;
    ostt_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    ostt_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ostt_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* rtl/ostt_regs.sv */
// APB configuration registers of the one-shot tick timer.
`timescale 1ns / 1ps

module ostt_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ostt_pkg::ADDR_W-1:0] paddr,
    input  logic [ostt_pkg::DATA_W-1:0] pwdata,
    output logic [ostt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output ostt_pkg::cfg_t              cfg
);

    ostt_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_shot_mode <= 1'b1;
            cfg_reg.period_ticks  <= ostt_pkg::PERIOD_RESET;
            cfg_reg.irq_enable    <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ostt_pkg::REG_ONE_SHOT_MODE: cfg_reg.one_shot_mode <= pwdata[0];
                ostt_pkg::REG_PERIOD_TICKS:  cfg_reg.period_ticks  <= pwdata;
                ostt_pkg::REG_IRQ_ENABLE:    cfg_reg.irq_enable    <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ostt_pkg::REG_ONE_SHOT_MODE: prdata = {31'b0, cfg_reg.one_shot_mode};
            ostt_pkg::REG_PERIOD_TICKS:  prdata = cfg_reg.period_ticks;
            ostt_pkg::REG_IRQ_ENABLE:    prdata = {31'b0, cfg_reg.irq_enable};
            default:                     prdata = '0;
        endcase
    end

endmodule

/* rtl/ostt_us_to_ticks.sv */
// Microsecond to tick conversion with saturation and clamp to 1..0xFFFFFFFF.
`timescale 1ns / 1ps

module ostt_us_to_ticks
(
    input  logic [63:0] diff_us,
    output logic [31:0] ticks
);

    logic        sat;
    logic [46:0] prod;
    logic [31:0] scaled;

    assign sat    = diff_us >= ostt_pkg::SAT_LIMIT;
    assign prod   = {16'b0, diff_us[30:0]} * {31'b0, ostt_pkg::TICK_MUL};
    assign scaled = prod[45:14];

    always_comb
    begin
        if (sat)
        begin
            ticks = ostt_pkg::MATCH_MAX;
        end
        else if (scaled == 32'd0)
        begin
            ticks = 32'd1;
        end
        else
        begin
            ticks = scaled;
        end
    end

endmodule

/* rtl/ostt_core.sv */
// Timer state: tick counter, converted tick time, match value, flag and clock.
`timescale 1ns / 1ps

module ostt_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  ostt_pkg::item_t   item,
    input  ostt_pkg::cfg_t    cfg,
    output ostt_pkg::result_t result
);

    // total_reg tracks clock_reg plus the elapsed tick count converted to microseconds
    logic [31:0] count_reg, count_next;
    logic [30:0] quot_reg, quot_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] match_reg, match_next;
    logic        flag_reg, flag_next;
    logic [63:0] clock_reg, clock_next;
    logic [63:0] total_reg, total_next;

    logic [31:0] count_inc;
    logic        wrap;
    logic [16:0] rem_sum;
    logic        carry;
    logic [15:0] rem_adv;
    logic [31:0] match_force;
    logic        wake_passed;
    logic [63:0] diff_us;
    logic [31:0] conv_ticks;
    logic [31:0] arm_match;

    assign count_inc   = count_reg + 32'd1;
    assign wrap        = (count_reg == ostt_pkg::MATCH_MAX);
    assign rem_sum     = {1'b0, rem_reg} + ostt_pkg::REM_STEP;
    assign carry       = rem_sum >= {1'b0, ostt_pkg::TICK_MUL};
    assign rem_adv     = carry ? 16'(rem_sum - {1'b0, ostt_pkg::TICK_MUL}) : rem_sum[15:0];
    assign match_force = cfg.one_shot_mode ? match_reg : cfg.period_ticks;
    assign wake_passed = item.wakeup_us <= total_reg;
    assign diff_us     = item.wakeup_us - total_reg;
    assign arm_match   = wake_passed ? 32'd1 : conv_ticks;

    ostt_us_to_ticks u_conv
    (
        .diff_us (diff_us),
        .ticks   (conv_ticks)
    );

    always_comb
    begin
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        match_next = match_reg;
        flag_next  = flag_reg;
        clock_next = clock_reg;
        total_next = total_reg;
        if (step_en)
        begin
            case (item.operation)
                ostt_pkg::OP_TICK:
                begin
                    count_next = count_inc;
                    if (wrap)
                    begin
                        quot_next  = '0;
                        rem_next   = '0;
                        total_next = clock_reg;
                    end
                    else
                    begin
                        rem_next   = rem_adv;
                        quot_next  = quot_reg + {30'b0, carry};
                        total_next = total_reg + {63'b0, carry};
                    end
                    if (count_inc == match_force)
                    begin
                        flag_next = 1'b1;
                    end
                end
                ostt_pkg::OP_ARM_WAKEUP:
                begin
                    if (cfg.one_shot_mode)
                    begin
                        clock_next = total_reg;
                        count_next = '0;
                        quot_next  = '0;
                        rem_next   = '0;
                        match_next = arm_match;
                        flag_next  = 1'b0;
                    end
                end
                ostt_pkg::OP_ACK:
                begin
                    count_next = '0;
                    quot_next  = '0;
                    rem_next   = '0;
                    flag_next  = 1'b0;
                    if (cfg.one_shot_mode)
                    begin
                        clock_next = total_reg;
                        match_next = ostt_pkg::MATCH_MAX;
                    end
                    else
                    begin
                        total_next = clock_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.irq_pending = flag_next & cfg.irq_enable;
    assign result.time_us     = cfg.one_shot_mode ? total_next : clock_next;
    assign result.match_ticks = cfg.one_shot_mode ? match_next : cfg.period_ticks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
            match_reg <= ostt_pkg::PERIOD_RESET;
            flag_reg  <= 1'b0;
            clock_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
            match_reg <= match_next;
            flag_reg  <= flag_next;
            clock_reg <= clock_next;
            total_reg <= total_next;
        end
    end

endmodule
